// ===== hdl/cpct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpct_pkg;

	localparam int COORD_W   = 32;
	localparam int RAD_W     = COORD_W - 1;
	localparam int TOL_W     = 16;
	localparam int UNIT_BITS = 30;

	localparam int DIV_W  = COORD_W + 1;
	localparam int Q_W    = UNIT_BITS + 1;
	localparam int SQ_W   = 2 * DIV_W;
	localparam int ROOT_W = SQ_W / 2;

	localparam int SQRT_LAT = ROOT_W + 1;
	localparam int DIV_LAT  = Q_W + 1;

	localparam int SUM_ST     = 4;
	localparam int DIS_ST     = SUM_ST + SQRT_LAT;
	localparam int DIV_IN_ST  = DIS_ST + 1;
	localparam int DIV_OUT_ST = DIV_IN_ST + DIV_LAT;
	localparam int S_ST       = DIV_OUT_ST + 1;
	localparam int S_OUT_ST   = S_ST + SQRT_LAT;
	localparam int LAST_ST    = S_OUT_ST + 5;

	typedef struct packed {
		logic signed [COORD_W-1:0] c1x;
		logic signed [COORD_W-1:0] c1y;
		logic signed [COORD_W-1:0] c2x;
		logic signed [COORD_W-1:0] c2y;
		logic [RAD_W-1:0]          r1;
		logic [RAD_W-1:0]          r2;
	} circles_t;

	typedef struct packed {
		circles_t         cir;
		logic [DIV_W-1:0] adx;
		logic [DIV_W-1:0] ady;
		logic             sx;
		logic             sy;
	} sa_t;

	typedef struct packed {
		circles_t cir;
		logic     sx;
		logic     sy;
		logic     gt;
		logic     out_ok;
		logic     in_ok;
	} sb_t;

	typedef struct packed {
		circles_t                  cir;
		logic signed [COORD_W-1:0] ux;
		logic signed [COORD_W-1:0] uy;
		logic [Q_W-1:0]            cvo;
		logic [Q_W-1:0]            cvi;
		logic                      gt;
		logic                      out_ok;
		logic                      in_ok;
	} sc_t;

	typedef struct packed {
		circles_t cir;
		logic     out_ok;
		logic     in_ok;
	} sd_t;

	typedef struct packed {
		logic                      found;
		logic                      inner_line;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic                      last;
	} tangent_t;

endpackage

`default_nettype wire

// ===== hdl/cpct_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cpct_in_if;
	import cpct_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] first_center_x;
	logic signed [COORD_W-1:0] first_center_y;
	logic [RAD_W-1:0]          first_radius;
	logic signed [COORD_W-1:0] second_center_x;
	logic signed [COORD_W-1:0] second_center_y;
	logic [RAD_W-1:0]          second_radius;

	modport source (
		output valid, first_center_x, first_center_y, first_radius,
		output second_center_x, second_center_y, second_radius,
		input  ready
	);

	modport sink (
		input  valid, first_center_x, first_center_y, first_radius,
		input  second_center_x, second_center_y, second_radius,
		output ready
	);

endinterface

`default_nettype wire

// ===== hdl/cpct_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cpct_out_if;
	import cpct_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      found;
	logic                      inner_line;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic                      last;

	modport source (
		output valid, found, inner_line, start_x, start_y, end_x, end_y, last,
		input  ready
	);

	modport sink (
		input  valid, found, inner_line, start_x, start_y, end_x, end_y, last,
		output ready
	);

endinterface

`default_nettype wire

// ===== hdl/circle_pair_common_tangents.sv =====
`timescale 1ns / 1ps
`default_nettype none

// port       dir  word
// circles    in   two circles: centres and radii
// tangents   out  one tangent segment, or a no-tangent marker; last ends the set
// cfg        in   tolerance write (cfg_we, cfg_wdata)
//
// A pair may enter every cycle while the pipeline is not stalled; its first result
// word is presented after 111 pipeline stages, the sequencer and the output register.
// Each pair gives one to four words, one word per cycle on tangents while the sink
// is ready, so the rate at which pairs go through is set by the result port.
// The pipeline advances as one; once a pair waits at the tail while the sequencer
// still has result words of an earlier pair to send, every stage stalls.
// arst_n clears valid bits, the sequencer and sets tolerance to 1.

module circle_pair_common_tangents (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cpct_pkg::TOL_W-1:0]  cfg_wdata,
	cpct_in_if.sink                     circles,
	cpct_out_if.source                  tangents
);
	import cpct_pkg::*;

	function automatic logic signed [COORD_W-1:0] sat(input logic [COORD_W+2:0] v);
		logic signed [COORD_W-1:0] r;
		if (v[COORD_W+2:COORD_W-1] == 4'b0000 || v[COORD_W+2:COORD_W-1] == 4'b1111)
			r = v[COORD_W-1:0];
		else if (v[COORD_W+2])
			r = {1'b1, {(COORD_W-1){1'b0}}};
		else
			r = {1'b0, {(COORD_W-1){1'b1}}};
		return r;
	endfunction

	logic [TOL_W-1:0] tol_q;
	logic             en;
	logic [LAST_ST:1] vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[LAST_ST-1:1], circles.valid};
		end
	end

	assign circles.ready = en;

	// s1 .. s4: deltas and squared distance
	circles_t          cir_s1;
	sa_t               sa_s2, sa_s3, sa_s4;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3, sum_s4;
	logic signed [DIV_W-1:0] dx, dy;

	assign dx = {cir_s1.c2x[COORD_W-1], cir_s1.c2x} - {cir_s1.c1x[COORD_W-1], cir_s1.c1x};
	assign dy = {cir_s1.c2y[COORD_W-1], cir_s1.c2y} - {cir_s1.c1y[COORD_W-1], cir_s1.c1y};

	always_ff @(posedge clk) begin
		if (en) begin
			cir_s1.c1x <= circles.first_center_x;
			cir_s1.c1y <= circles.first_center_y;
			cir_s1.r1  <= circles.first_radius;
			cir_s1.c2x <= circles.second_center_x;
			cir_s1.c2y <= circles.second_center_y;
			cir_s1.r2  <= circles.second_radius;

			sa_s2.cir <= cir_s1;
			sa_s2.sx  <= dx[DIV_W-1];
			sa_s2.sy  <= dy[DIV_W-1];
			sa_s2.adx <= dx[DIV_W-1] ? DIV_W'(-dx) : DIV_W'(dx);
			sa_s2.ady <= dy[DIV_W-1] ? DIV_W'(-dy) : DIV_W'(dy);

			sa_s3  <= sa_s2;
			sqx_s3 <= SQ_W'(sa_s2.adx) * SQ_W'(sa_s2.adx);
			sqy_s3 <= SQ_W'(sa_s2.ady) * SQ_W'(sa_s2.ady);

			sa_s4  <= sa_s3;
			sum_s4 <= sqx_s3 + sqy_s3;
		end
	end

	logic [ROOT_W-1:0] dis_rt;
	sa_t               sa_d [SUM_ST+1:DIS_ST];

	cpct_sqrt u_sqrt_dis (.clk(clk), .en(en), .rad(sum_s4), .root(dis_rt));

	always_ff @(posedge clk) begin
		if (en) begin
			sa_d[SUM_ST+1] <= sa_s4;
			for (int k = SUM_ST + 2; k <= DIS_ST; k++) sa_d[k] <= sa_d[k-1];
		end
	end

	// s39: tests and divider operands
	logic [ROOT_W-1:0] dis_s39;
	sb_t               sb_s39;
	logic [DIV_W-1:0]  adx_s39, ady_s39, rdiff_s39, rsum_s39;
	logic [RAD_W-1:0]  rd_r1, rd_r2, rdiff;
	logic [RAD_W:0]    rsum;
	logic              base_ok;

	assign rd_r1   = sa_d[DIS_ST].cir.r1;
	assign rd_r2   = sa_d[DIS_ST].cir.r2;
	assign rdiff   = (rd_r1 > rd_r2) ? rd_r1 - rd_r2 : rd_r2 - rd_r1;
	assign rsum    = {1'b0, rd_r1} + {1'b0, rd_r2};
	assign base_ok = dis_rt > ROOT_W'(tol_q) && rd_r1 > RAD_W'(tol_q)
	               && rd_r2 > RAD_W'(tol_q);

	always_ff @(posedge clk) begin
		if (en) begin
			dis_s39       <= dis_rt;
			adx_s39       <= sa_d[DIS_ST].adx;
			ady_s39       <= sa_d[DIS_ST].ady;
			rdiff_s39     <= DIV_W'(rdiff);
			rsum_s39      <= DIV_W'(rsum);
			sb_s39.cir    <= sa_d[DIS_ST].cir;
			sb_s39.sx     <= sa_d[DIS_ST].sx;
			sb_s39.sy     <= sa_d[DIS_ST].sy;
			sb_s39.gt     <= rd_r1 > rd_r2;
			sb_s39.out_ok <= base_ok
			              && (DIV_W+1)'(dis_rt) > (DIV_W+1)'(rdiff) + (DIV_W+1)'(tol_q);
			sb_s39.in_ok  <= base_ok
			              && (DIV_W+1)'(dis_rt) > (DIV_W+1)'(rsum) + (DIV_W+1)'(tol_q);
		end
	end

	logic [Q_W-1:0] uxm_q, uym_q, cvo_q, cvi_q;
	sb_t            sb_d [DIV_IN_ST+1:DIV_OUT_ST];

	cpct_div u_div_ux (.clk(clk), .en(en), .num(adx_s39),   .den(dis_s39), .quo(uxm_q));
	cpct_div u_div_uy (.clk(clk), .en(en), .num(ady_s39),   .den(dis_s39), .quo(uym_q));
	cpct_div u_div_co (.clk(clk), .en(en), .num(rdiff_s39), .den(dis_s39), .quo(cvo_q));
	cpct_div u_div_ci (.clk(clk), .en(en), .num(rsum_s39),  .den(dis_s39), .quo(cvi_q));

	always_ff @(posedge clk) begin
		if (en) begin
			sb_d[DIV_IN_ST+1] <= sb_s39;
			for (int k = DIV_IN_ST + 2; k <= DIV_OUT_ST; k++) sb_d[k] <= sb_d[k-1];
		end
	end

	// s72: clamp cosines, square them
	localparam logic [Q_W-1:0]    ONE_Q  = Q_W'(1) << UNIT_BITS;
	localparam logic [2*Q_W-2:0]  ONE_SQ = (2*Q_W-1)'(1) << (2 * UNIT_BITS);

	sc_t              sc_s72;
	logic [2*Q_W-2:0] sqo_s72, sqi_s72;
	logic [Q_W-1:0]   cvo_c, cvi_c;
	logic [Q_W:0]     uxe, uye;

	assign cvo_c = (cvo_q > ONE_Q) ? ONE_Q : cvo_q;
	assign cvi_c = (cvi_q > ONE_Q) ? ONE_Q : cvi_q;
	assign uxe   = {1'b0, uxm_q};
	assign uye   = {1'b0, uym_q};

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s72.cir    <= sb_d[DIV_OUT_ST].cir;
			sc_s72.ux     <= sb_d[DIV_OUT_ST].sx ? COORD_W'(-uxe) : COORD_W'(uxe);
			sc_s72.uy     <= sb_d[DIV_OUT_ST].sy ? COORD_W'(-uye) : COORD_W'(uye);
			sc_s72.cvo    <= cvo_c;
			sc_s72.cvi    <= cvi_c;
			sc_s72.gt     <= sb_d[DIV_OUT_ST].gt;
			sc_s72.out_ok <= sb_d[DIV_OUT_ST].out_ok;
			sc_s72.in_ok  <= sb_d[DIV_OUT_ST].in_ok;
			sqo_s72       <= (2*Q_W-1)'(cvo_c) * (2*Q_W-1)'(cvo_c);
			sqi_s72       <= (2*Q_W-1)'(cvi_c) * (2*Q_W-1)'(cvi_c);
		end
	end

	logic [ROOT_W-1:0] so_rt, si_rt;
	sc_t               sc_d [S_ST+1:S_OUT_ST];

	cpct_sqrt u_sqrt_so (.clk(clk), .en(en), .rad(SQ_W'(ONE_SQ - sqo_s72)), .root(so_rt));
	cpct_sqrt u_sqrt_si (.clk(clk), .en(en), .rad(SQ_W'(ONE_SQ - sqi_s72)), .root(si_rt));

	always_ff @(posedge clk) begin
		if (en) begin
			sc_d[S_ST+1] <= sc_s72;
			for (int k = S_ST + 2; k <= S_OUT_ST; k++) sc_d[k] <= sc_d[k-1];
		end
	end

	// s107 .. s111: direction, offsets, end points
	logic signed [COORD_W-1:0]   ao, ai, so, si, uxs, uys;
	logic signed [2*COORD_W-1:0] prod_s107 [0:7];
	sd_t                         sd_s107, sd_s108, sd_s109, sd_s110, sd_s111;
	logic [61:0]                 dmag_s108 [0:7];
	logic                        dsg_s108 [0:7];
	logic                        dsg_s109 [0:7];
	logic [61:0]                 pl_s109 [0:7][0:1];
	logic [61:0]                 ph_s109 [0:7][0:1];
	logic [COORD_W+1:0]          off_s110 [0:7][0:1];
	tangent_t                    lines_s111 [0:3];

	assign uxs = sc_d[S_OUT_ST].ux;
	assign uys = sc_d[S_OUT_ST].uy;
	assign ao  = sc_d[S_OUT_ST].gt ? COORD_W'({1'b0, sc_d[S_OUT_ST].cvo})
	                               : COORD_W'(-{1'b0, sc_d[S_OUT_ST].cvo});
	assign ai  = COORD_W'({1'b0, sc_d[S_OUT_ST].cvi});
	assign so  = COORD_W'({1'b0, so_rt[Q_W-1:0]});
	assign si  = COORD_W'({1'b0, si_rt[Q_W-1:0]});

	always_ff @(posedge clk) begin
		logic signed [2*COORD_W-1:0] d;
		logic [RAD_W-1:0]            r;
		logic [92:0]                 full;
		logic [COORD_W:0]            m;
		logic [COORD_W+2:0]          cs, ce;
		if (en) begin
			prod_s107[0] <= ao * uxs;
			prod_s107[1] <= so * uys;
			prod_s107[2] <= ao * uys;
			prod_s107[3] <= so * uxs;
			prod_s107[4] <= ai * uxs;
			prod_s107[5] <= si * uys;
			prod_s107[6] <= ai * uys;
			prod_s107[7] <= si * uxs;
			sd_s107.cir    <= sc_d[S_OUT_ST].cir;
			sd_s107.out_ok <= sc_d[S_OUT_ST].out_ok;
			sd_s107.in_ok  <= sc_d[S_OUT_ST].in_ok;

			for (int l = 0; l < 4; l++) begin
				for (int c = 0; c < 2; c++) begin
					if (c == 0)
						d = (l % 2 == 0) ? prod_s107[(l/2)*4] - prod_s107[(l/2)*4+1]
						                 : prod_s107[(l/2)*4] + prod_s107[(l/2)*4+1];
					else
						d = (l % 2 == 0) ? prod_s107[(l/2)*4+2] + prod_s107[(l/2)*4+3]
						                 : prod_s107[(l/2)*4+2] - prod_s107[(l/2)*4+3];
					dsg_s108[2*l+c]  <= d[2*COORD_W-1];
					dmag_s108[2*l+c] <= d[2*COORD_W-1] ? 62'(-d) : 62'(d);
				end
			end
			sd_s108 <= sd_s107;

			for (int k = 0; k < 8; k++) begin
				for (int j = 0; j < 2; j++) begin
					r = (j == 0) ? sd_s108.cir.r1 : sd_s108.cir.r2;
					pl_s109[k][j] <= 62'(r) * 62'(dmag_s108[k][30:0]);
					ph_s109[k][j] <= 62'(r) * 62'(dmag_s108[k][61:31]);
				end
				dsg_s109[k] <= dsg_s108[k];
			end
			sd_s109 <= sd_s108;

			for (int k = 0; k < 8; k++) begin
				for (int j = 0; j < 2; j++) begin
					full = {ph_s109[k][j], 31'd0} + 93'(pl_s109[k][j]);
					m    = full[92:60];
					off_s110[k][j] <= dsg_s109[k] ? (COORD_W+2)'(-{1'b0, m})
					                              : {1'b0, m};
				end
			end
			sd_s110 <= sd_s109;

			for (int l = 0; l < 4; l++) begin
				lines_s111[l].found      <= 1'b1;
				lines_s111[l].inner_line <= (l >= 2);
				lines_s111[l].last       <= 1'b0;
				cs = {{3{sd_s110.cir.c1x[COORD_W-1]}}, sd_s110.cir.c1x}
				   + {off_s110[2*l][0][COORD_W+1], off_s110[2*l][0]};
				lines_s111[l].start_x <= sat(cs);
				cs = {{3{sd_s110.cir.c1y[COORD_W-1]}}, sd_s110.cir.c1y}
				   + {off_s110[2*l+1][0][COORD_W+1], off_s110[2*l+1][0]};
				lines_s111[l].start_y <= sat(cs);
				if (l >= 2) begin
					ce = {{3{sd_s110.cir.c2x[COORD_W-1]}}, sd_s110.cir.c2x}
					   - {off_s110[2*l][1][COORD_W+1], off_s110[2*l][1]};
					lines_s111[l].end_x <= sat(ce);
					ce = {{3{sd_s110.cir.c2y[COORD_W-1]}}, sd_s110.cir.c2y}
					   - {off_s110[2*l+1][1][COORD_W+1], off_s110[2*l+1][1]};
					lines_s111[l].end_y <= sat(ce);
				end else begin
					ce = {{3{sd_s110.cir.c2x[COORD_W-1]}}, sd_s110.cir.c2x}
					   + {off_s110[2*l][1][COORD_W+1], off_s110[2*l][1]};
					lines_s111[l].end_x <= sat(ce);
					ce = {{3{sd_s110.cir.c2y[COORD_W-1]}}, sd_s110.cir.c2y}
					   + {off_s110[2*l+1][1][COORD_W+1], off_s110[2*l+1][1]};
					lines_s111[l].end_y <= sat(ce);
				end
			end
			sd_s111 <= sd_s110;
		end
	end

	// result sequencer and output register
	tangent_t list  [0:3];
	tangent_t seq_q [0:3];
	tangent_t od_q;
	tangent_t od_d;
	logic [1:0] lst, last_q, idx_q;
	logic       seq_v_q, ov_q, out_load, emit, seq_done, seq_take, load_seq;

	always_comb begin
		for (int l = 0; l < 4; l++) list[l] = '0;
		lst = 2'd0;
		if (sd_s111.out_ok) begin
			for (int l = 0; l < 4; l++) list[l] = lines_s111[l];
			lst = sd_s111.in_ok ? 2'd3 : 2'd1;
		end else if (sd_s111.in_ok) begin
			list[0] = lines_s111[2];
			list[1] = lines_s111[3];
			lst     = 2'd1;
		end
	end

	always_comb begin
		od_d      = seq_q[idx_q];
		od_d.last = (idx_q == last_q);
	end

	assign out_load = !ov_q || tangents.ready;
	assign emit     = seq_v_q && out_load;
	assign seq_done = emit && (idx_q == last_q);
	assign seq_take = !seq_v_q || seq_done;
	assign load_seq = seq_take && vld[LAST_ST];
	assign en       = !vld[LAST_ST] || seq_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_q <= 1'b0;
			idx_q   <= 2'd0;
			ov_q    <= 1'b0;
		end else begin
			if (load_seq) begin
				seq_v_q <= 1'b1;
				idx_q   <= 2'd0;
			end else if (seq_done) begin
				seq_v_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (out_load) ov_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (load_seq) begin
			seq_q  <= list;
			last_q <= lst;
		end
		if (emit) begin
			od_q <= od_d;
		end
	end

	assign tangents.valid      = ov_q;
	assign tangents.found      = od_q.found;
	assign tangents.inner_line = od_q.inner_line;
	assign tangents.start_x    = od_q.start_x;
	assign tangents.start_y    = od_q.start_y;
	assign tangents.end_x      = od_q.end_x;
	assign tangents.end_y      = od_q.end_y;
	assign tangents.last       = od_q.last;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_v_q |-> idx_q <= last_q)
		else $error("sequencer index past last result");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !od_q.found |-> od_q.last && !od_q.inner_line)
		else $error("no-tangent word not alone");

	a_inner_found: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && od_q.inner_line |-> od_q.found)
		else $error("inner flag without a tangent");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld[LAST_ST] && !en |=> vld[LAST_ST] && $stable(sd_s111))
		else $error("pipeline tail moved while stalled");

endmodule

`default_nettype wire

// ===== hdl/cpct_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpct_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cpct_pkg::DIV_W-1:0]   num,
	input  logic [cpct_pkg::DIV_W-1:0]   den,
	output logic [cpct_pkg::Q_W-1:0]     quo
);
	import cpct_pkg::*;

	// trunc(num * 2^30 / den), one quotient bit per stage
	logic [DIV_W-1:0] rem_s [0:Q_W-1];
	logic [DIV_W-1:0] den_s [0:Q_W-1];
	logic [Q_W-1:0]   quo_s [1:Q_W];
	logic             lsb_s0;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, num[DIV_W-1:1]};
			den_s[0] <= den;
			lsb_s0   <= num[0];
		end
	end

	genvar i;
	generate
		for (i = 0; i < Q_W; i++) begin : g_step
			logic [DIV_W:0] trial;
			logic           ge;

			if (i == 0) begin : g_first
				assign trial = {rem_s[0], lsb_s0};
			end else begin : g_rest
				assign trial = {rem_s[i], 1'b0};
			end

			assign ge = trial >= {1'b0, den_s[i]};

			if (i == 0) begin : g_q0
				always_ff @(posedge clk) begin
					if (en) quo_s[1] <= {{(Q_W-1){1'b0}}, ge};
				end
			end else begin : g_qn
				always_ff @(posedge clk) begin
					if (en) quo_s[i+1] <= {quo_s[i][Q_W-2:0], ge};
				end
			end

			if (i < Q_W - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[i+1] <= ge ? DIV_W'(trial - {1'b0, den_s[i]})
						                 : trial[DIV_W-1:0];
						den_s[i+1] <= den_s[i];
					end
				end
			end
		end
	endgenerate

	assign quo = quo_s[Q_W];

endmodule

`default_nettype wire

// ===== hdl/cpct_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpct_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cpct_pkg::SQ_W-1:0]     rad,
	output logic [cpct_pkg::ROOT_W-1:0]   root
);
	import cpct_pkg::*;

	// floor(sqrt(rad)), one root bit per stage
	logic [SQ_W-1:0]     val_s  [0:ROOT_W-1];
	logic [ROOT_W+1:0]   rem_s  [1:ROOT_W-1];
	logic [ROOT_W-1:0]   root_s [1:ROOT_W];

	always_ff @(posedge clk) begin
		if (en) val_s[0] <= rad;
	end

	genvar i;
	generate
		for (i = 0; i < ROOT_W; i++) begin : g_step
			logic [ROOT_W+3:0] remx;
			logic [ROOT_W+1:0] trial;
			logic              ge;

			if (i == 0) begin : g_first
				assign remx  = {{(ROOT_W+2){1'b0}}, val_s[0][SQ_W-1 -: 2]};
				assign trial = (ROOT_W+2)'(1);
			end else begin : g_rest
				assign remx  = {rem_s[i], val_s[i][SQ_W-1 -: 2]};
				assign trial = {root_s[i], 2'b01};
			end

			assign ge = remx >= {2'b00, trial};

			if (i == 0) begin : g_r0
				always_ff @(posedge clk) begin
					if (en) root_s[1] <= {{(ROOT_W-1){1'b0}}, ge};
				end
			end else begin : g_rn
				always_ff @(posedge clk) begin
					if (en) root_s[i+1] <= {root_s[i][ROOT_W-2:0], ge};
				end
			end

			if (i < ROOT_W - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[i+1] <= ge ? (ROOT_W+2)'(remx - {2'b00, trial})
						                 : remx[ROOT_W+1:0];
						val_s[i+1] <= val_s[i] << 2;
					end
				end
			end
		end
	endgenerate

	assign root = root_s[ROOT_W];

endmodule

`default_nettype wire
